/* sv/scac_pkg.sv */
// Shared types, widths and constants of the scan channel activity classifier.
package scac_pkg;

   localparam int MODE_W      = 2;
   localparam int CHAN_W      = 8;
   localparam int RSSI_W      = 9;
   localparam int NOISE_W     = 8;
   localparam int SQ_W        = 8;
   localparam int BASE_W      = 16;
   localparam int SCORE_W     = 5;
   localparam int WCOUNT_W    = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam int CHANNELS_DEFAULT  = 256;
   localparam int TOP_DEPTH_DEFAULT = 4;

   localparam logic [BASE_W-1:0]        UNKNOWN_BASELINE = 16'hFFFF;
   localparam logic [BASE_W:0]          RSSI_MARGIN      = 17'd16;
   localparam logic [SQ_W-1:0]          SQUELCH_MARGIN   = 8'd8;
   localparam logic [RSSI_W:0]          WEAK_MARGIN      = 10'd8;
   localparam logic [NOISE_W-1:0]       NOISE_MARGIN     = 8'd5;
   localparam logic signed [SCORE_W-1:0] ADAPT_UP        = 5'sd8;
   localparam logic signed [SCORE_W-1:0] SCORE_FLOOR     = 5'sb10000;
   localparam logic [WCOUNT_W-1:0]      WARMUP_SAMPLES   = 6'd32;
   localparam logic [WCOUNT_W-1:0]      WARMUP_COUNT_MAX = 6'd63;

   typedef enum logic [MODE_W-1:0] {
      MODE_MEASURE = 2'd0,
      MODE_COMMIT  = 2'd1,
      MODE_DROP    = 2'd2,
      MODE_RESTART = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SQUELCH_LOW    = 2'd0,
      CSR_SQUELCH_HIGH   = 2'd1,
      CSR_WARMUP_ALLOWED = 2'd2
   } csr_index_type;

   typedef struct packed {
      mode_type             mode;
      logic [CHAN_W-1:0]    channel;
      logic [RSSI_W-1:0]    rssi;
      logic [NOISE_W-1:0]   noise;
      logic                 low_band;
   } item_type;

   typedef struct packed {
      logic [NOISE_W-1:0]         ref_level;
      logic                       ref_valid;
      logic signed [SCORE_W-1:0]  score;
      logic [WCOUNT_W-1:0]        count;
      logic                       warmup_on;
   } noise_state_type;

   typedef struct packed {
      logic                 flag;
      logic [CHAN_W-1:0]    channel;
      logic [RSSI_W-1:0]    rssi;
      logic [NOISE_W-1:0]   noise;
   } pending_type;

   typedef struct packed {
      logic [SQ_W-1:0] sq_low;
      logic [SQ_W-1:0] sq_high;
      logic            warmup_allowed;
   } cfg_type;

endpackage

/* sv/scac_req_if.sv */
// Request channel interface: one channel reading or control command.
interface scac_req_if;
   import scac_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [CHAN_W-1:0]    channel_index;
   logic [RSSI_W-1:0]    rssi_level;
   logic [NOISE_W-1:0]   noise_level;
   logic                 low_band;

   modport source (output valid, mode, channel_index, rssi_level, noise_level, low_band,
                   input ready);
   modport sink   (input valid, mode, channel_index, rssi_level, noise_level, low_band,
                   output ready);
endinterface

/* sv/scac_rsp_if.sv */
// Response channel interface: classification and noise reference status.
interface scac_rsp_if;
   import scac_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 full_tune;
   logic [NOISE_W-1:0]   noise_reference;
   logic                 reference_valid;
   logic                 warming_up;

   modport source (output valid, full_tune, noise_reference, reference_valid, warming_up,
                   input ready);
   modport sink   (input valid, full_tune, noise_reference, reference_valid, warming_up,
                   output ready);
endinterface

/* sv/scac_baseline_ram.sv */
// Per-channel RSSI baseline memory with a sweep that marks every entry unknown.
module scac_baseline_ram #(
   parameter int CHANNELS = scac_pkg::CHANNELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(CHANNELS)-1:0]   rd_addr,
   output logic [scac_pkg::BASE_W-1:0]   rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(CHANNELS)-1:0]   wr_addr,
   input  logic [scac_pkg::BASE_W-1:0]   wr_data,
   input  logic                          clear_start,
   output logic                          busy
);
   import scac_pkg::*;

   localparam int AW = $clog2(CHANNELS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(CHANNELS - 1);

   logic [BASE_W-1:0] mem [CHANNELS];
   logic [BASE_W-1:0] rd_data_ff;
   logic              busy_ff, busy_in;
   logic [AW-1:0]     sweep_ff, sweep_in;

   always_comb begin
      busy_in  = busy_ff;
      sweep_in = sweep_ff;
      if (clear_start) begin
         busy_in  = 1'b1;
         sweep_in = '0;
      end else if (busy_ff) begin
         sweep_in = sweep_ff + AW'(1);
         if (sweep_ff == LAST_ADDR) begin
            busy_in  = 1'b0;
            sweep_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         sweep_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[sweep_ff] <= UNKNOWN_BASELINE;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;
endmodule

/* sv/scac_classify.sv */
// Per-request decision logic: candidate test, warm-up ranking and store updates.
module scac_classify #(
   parameter int TOP_DEPTH = scac_pkg::TOP_DEPTH_DEFAULT
) (
   input  scac_pkg::item_type                               item,
   input  logic                                             in_range,
   input  logic [scac_pkg::BASE_W-1:0]                      baseline,
   input  scac_pkg::cfg_type                                cfg,
   input  scac_pkg::noise_state_type                        state,
   input  logic [TOP_DEPTH-1:0][scac_pkg::NOISE_W-1:0]      top_noise,
   input  scac_pkg::pending_type                            pending,
   output scac_pkg::noise_state_type                        state_in,
   output logic [TOP_DEPTH-1:0][scac_pkg::NOISE_W-1:0]      top_in,
   output scac_pkg::pending_type                            pending_in,
   output logic                                             wr_en,
   output logic [scac_pkg::BASE_W-1:0]                      wr_data,
   output logic                                             full_tune
);
   import scac_pkg::*;

   function automatic noise_state_type track_noise(noise_state_type s,
                                                   logic [NOISE_W-1:0] noise);
      noise_state_type r;
      logic signed [SCORE_W-1:0] sc;
      r  = s;
      sc = s.score;
      if (!s.ref_valid) begin
         r.ref_level = noise;
         r.ref_valid = 1'b1;
         r.score     = '0;
      end else if (noise > s.ref_level) begin
         if (sc < ADAPT_UP) sc = sc + 5'sd1;
         if (sc >= ADAPT_UP) begin
            r.ref_level = s.ref_level + 8'd1;
            sc          = '0;
         end
         r.score = sc;
      end else if (noise < s.ref_level) begin
         if (sc > SCORE_FLOOR) sc = sc - 5'sd1;
         if (sc <= SCORE_FLOOR) begin
            r.ref_level = s.ref_level - 8'd1;
            sc          = '0;
         end
         r.score = sc;
      end
      return r;
   endfunction

   function automatic logic [BASE_W-1:0] blend(logic [BASE_W-1:0] b,
                                                logic [RSSI_W-1:0] rssi);
      logic [BASE_W+3:0] acc;
      acc = (BASE_W+4)'({b, 3'b000}) - (BASE_W+4)'(b) + (BASE_W+4)'(rssi) + 20'd4;
      if (b == UNKNOWN_BASELINE) return BASE_W'(rssi);
      return acc[BASE_W+2:3];
   endfunction

   logic [BASE_W:0]   trig;
   logic [SQ_W-1:0]   sq, sq_open;
   logic [RSSI_W:0]   rssi_up;
   logic              base_unknown, rssi_cand, noise_cand, cand;
   logic [NOISE_W-1:0] noise_thr;
   logic [TOP_DEPTH-1:0] gt;
   logic [TOP_DEPTH-1:0][NOISE_W-1:0] top_ins;
   logic [WCOUNT_W-1:0] count_next;

   always_comb begin
      base_unknown = (baseline == UNKNOWN_BASELINE);
      trig = {1'b0, baseline} + RSSI_MARGIN;
      if (trig > {1'b0, UNKNOWN_BASELINE}) trig = {1'b0, UNKNOWN_BASELINE};
      sq      = item.low_band ? cfg.sq_low : cfg.sq_high;
      sq_open = (sq > SQUELCH_MARGIN) ? sq - SQUELCH_MARGIN : '0;
      rssi_up = {1'b0, item.rssi} + WEAK_MARGIN;
      rssi_cand = base_unknown ||
                  (((BASE_W+1)'(rssi_up) >= trig) && (rssi_up >= (RSSI_W+1)'(sq_open)));
      noise_thr  = (state.ref_level > NOISE_MARGIN) ? state.ref_level - NOISE_MARGIN : '0;
      noise_cand = state.ref_valid && (item.noise <= noise_thr);
      cand = (base_unknown && state.ref_valid) ? noise_cand : (rssi_cand || noise_cand);
   end

   always_comb begin
      for (int i = 0; i < TOP_DEPTH; i++) begin
         gt[i] = item.noise > top_noise[i];
      end
      top_ins[0] = gt[0] ? item.noise : top_noise[0];
      for (int i = 1; i < TOP_DEPTH; i++) begin
         if (!gt[i]) top_ins[i] = top_noise[i];
         else if (gt[i-1]) top_ins[i] = top_noise[i-1];
         else top_ins[i] = item.noise;
      end
      count_next = (state.count < WARMUP_COUNT_MAX) ? state.count + 6'd1 : state.count;
   end

   always_comb begin
      state_in   = state;
      top_in     = top_noise;
      pending_in = pending;
      wr_en      = 1'b0;
      wr_data    = blend(baseline, item.rssi);
      full_tune  = 1'b0;
      unique case (item.mode)
         MODE_MEASURE: begin
            if (state.warmup_on) begin
               top_in         = top_ins;
               state_in.count = count_next;
               if (count_next >= WARMUP_SAMPLES) begin
                  state_in.ref_level = top_ins[TOP_DEPTH-1];
                  state_in.ref_valid = 1'b1;
                  state_in.warmup_on = 1'b0;
               end
               pending_in.flag = 1'b0;
            end else if (!cand) begin
               wr_en           = in_range;
               state_in        = track_noise(state, item.noise);
               pending_in.flag = 1'b0;
            end else begin
               pending_in.flag    = 1'b1;
               pending_in.channel = item.channel;
               pending_in.rssi    = item.rssi;
               pending_in.noise   = item.noise;
               full_tune          = 1'b1;
            end
         end
         MODE_COMMIT: begin
            if (pending.flag) begin
               wr_en            = in_range;
               wr_data          = blend(baseline, pending.rssi);
               state_in         = track_noise(state, pending.noise);
               pending_in.flag  = 1'b0;
               pending_in.rssi  = '0;
               pending_in.noise = '0;
            end
         end
         MODE_DROP: begin
            pending_in.flag = 1'b0;
         end
         MODE_RESTART: begin
            state_in.ref_level = '0;
            state_in.ref_valid = 1'b0;
            state_in.score     = '0;
            state_in.count     = '0;
            state_in.warmup_on = cfg.warmup_allowed;
            top_in             = '0;
            pending_in         = '0;
         end
      endcase
   end
endmodule

/* sv/scan_channel_activity_classifier.sv */
// Top level: request stages, baseline memory, noise state and response register.
//
// One response per request. Requests are taken one per cycle unless response back-pressure,
// a restart or the baseline memory sweep holds ready low; each response passes the stage that
// issues the baseline memory read and the stage that classifies and writes back, and is
// forwarded in order through a response register. A restart request holds off new requests
// until it has left the pipeline and the baseline memory sweep has marked all CHANNELS
// entries unknown, one entry per cycle; the same sweep runs after reset. Configuration writes
// are taken at any time.
module scan_channel_activity_classifier #(
   parameter int CHANNELS  = scac_pkg::CHANNELS_DEFAULT,
   parameter int TOP_DEPTH = scac_pkg::TOP_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   scac_req_if.sink                         req_chan,
   scac_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [scac_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [scac_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import scac_pkg::*;

   localparam int AW = $clog2(CHANNELS);

   cfg_type                          cfg_ff;
   noise_state_type                  state_ff, state_in;
   logic [TOP_DEPTH-1:0][NOISE_W-1:0] top_ff, top_in;
   pending_type                      pending_ff, pending_in;

   logic        a_valid_ff, b_valid_ff, rsp_valid_ff;
   item_type    a_item_ff, b_item_ff;
   logic [AW-1:0] b_addr_ff;
   logic        b_in_range_ff;

   logic        byp_valid_ff;
   logic [AW-1:0] byp_addr_ff;
   logic [BASE_W-1:0] byp_data_ff;

   logic        rsp_full_ff, rsp_ref_valid_ff, rsp_warm_ff;
   logic [NOISE_W-1:0] rsp_ref_ff;

   logic        accept, a_move, b_advance, clear_start, ram_busy;
   logic [CHAN_W-1:0] rd_chan;
   logic [AW-1:0] rd_addr;
   logic        rd_in_range;
   logic [BASE_W-1:0] ram_rd_data, baseline;
   logic        wr_en, full_tune;
   logic [BASE_W-1:0] wr_data;
   item_type    req_item;

   assign req_item.mode     = mode_type'(req_chan.mode);
   assign req_item.channel  = req_chan.channel_index;
   assign req_item.rssi     = req_chan.rssi_level;
   assign req_item.noise    = req_chan.noise_level;
   assign req_item.low_band = req_chan.low_band;

   assign b_advance   = b_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign a_move      = a_valid_ff && (!b_valid_ff || b_advance);
   assign req_chan.ready = !ram_busy
                        && !(a_valid_ff && a_item_ff.mode == MODE_RESTART)
                        && !(b_valid_ff && b_item_ff.mode == MODE_RESTART)
                        && (!a_valid_ff || a_move);
   assign accept      = req_chan.valid && req_chan.ready;
   assign clear_start = b_advance && b_item_ff.mode == MODE_RESTART;

   // commit reads the pending channel as it stands once the request ahead has retired
   always_comb begin
      rd_chan = a_item_ff.channel;
      if (a_item_ff.mode == MODE_COMMIT) begin
         rd_chan = (b_valid_ff && b_item_ff.mode == MODE_MEASURE) ? b_item_ff.channel
                                                                  : pending_ff.channel;
      end
      rd_addr     = AW'(rd_chan);
      rd_in_range = 32'(rd_chan) < CHANNELS;
   end

   scac_baseline_ram #(.CHANNELS(CHANNELS)) u_ram (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (a_move),
      .rd_addr     (rd_addr),
      .rd_data     (ram_rd_data),
      .wr_en       (b_advance && wr_en),
      .wr_addr     (b_addr_ff),
      .wr_data     (wr_data),
      .clear_start (clear_start),
      .busy        (ram_busy)
   );

   always_comb begin
      if (!b_in_range_ff) baseline = UNKNOWN_BASELINE;
      else if (byp_valid_ff && byp_addr_ff == b_addr_ff) baseline = byp_data_ff;
      else baseline = ram_rd_data;
   end

   scac_classify #(.TOP_DEPTH(TOP_DEPTH)) u_classify (
      .item       (b_item_ff),
      .in_range   (b_in_range_ff),
      .baseline   (baseline),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .top_noise  (top_ff),
      .pending    (pending_ff),
      .state_in   (state_in),
      .top_in     (top_in),
      .pending_in (pending_in),
      .wr_en      (wr_en),
      .wr_data    (wr_data),
      .full_tune  (full_tune)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sq_low         <= '0;
         cfg_ff.sq_high        <= '0;
         cfg_ff.warmup_allowed <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SQUELCH_LOW:    cfg_ff.sq_low         <= csr_wdata;
            CSR_SQUELCH_HIGH:   cfg_ff.sq_high        <= csr_wdata;
            CSR_WARMUP_ALLOWED: cfg_ff.warmup_allowed <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= noise_state_type'{ref_level: '0, ref_valid: 1'b0, score: '0,
                                           count: '0, warmup_on: 1'b1};
         top_ff       <= '0;
         pending_ff   <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_valid_ff <= 1'b0;
      end else begin
         if (accept) a_valid_ff <= 1'b1;
         else if (a_move) a_valid_ff <= 1'b0;
         if (a_move) b_valid_ff <= 1'b1;
         else if (b_advance) b_valid_ff <= 1'b0;
         if (b_advance) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
         if (b_advance) begin
            state_ff   <= state_in;
            top_ff     <= top_in;
            pending_ff <= pending_in;
         end
         if (clear_start) byp_valid_ff <= 1'b0;
         else if (b_advance && wr_en) byp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) a_item_ff <= req_item;
      if (a_move) begin
         b_item_ff     <= a_item_ff;
         b_addr_ff     <= rd_addr;
         b_in_range_ff <= rd_in_range;
      end
      if (b_advance && wr_en) begin
         byp_addr_ff <= b_addr_ff;
         byp_data_ff <= wr_data;
      end
      if (b_advance) begin
         rsp_full_ff      <= full_tune;
         rsp_ref_ff       <= state_in.ref_level;
         rsp_ref_valid_ff <= state_in.ref_valid;
         rsp_warm_ff      <= state_in.warmup_on;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.full_tune       = rsp_full_ff;
   assign rsp_chan.noise_reference = rsp_ref_ff;
   assign rsp_chan.reference_valid = rsp_ref_valid_ff;
   assign rsp_chan.warming_up      = rsp_warm_ff;
endmodule

/* sv/scac_checker.sv */
// Port-level checker for the classifier and its bind to the top level.
module scac_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [scac_pkg::MODE_W-1:0]   req_mode,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_full_tune,
   input logic [scac_pkg::NOISE_W-1:0]  rsp_noise_reference,
   input logic                          rsp_reference_valid,
   input logic                          rsp_warming_up
);
   import scac_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_full_tune)
         && $stable(rsp_noise_reference) && $stable(rsp_reference_valid)
         && $stable(rsp_warming_up))
      else $error("response changed while stalled");

   a_warm_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_warming_up |-> !rsp_full_tune && !rsp_reference_valid)
      else $error("warm-up response flagged a candidate or a valid reference");

   a_ref_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reference_valid |-> rsp_noise_reference == '0)
      else $error("noise reference nonzero while not established");

   a_restart_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_RESTART |=> !req_ready)
      else $error("request taken right after a restart");
endmodule

bind scan_channel_activity_classifier scac_port_checker u_scac_port_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .req_mode            (req_chan.mode),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_full_tune       (rsp_chan.full_tune),
   .rsp_noise_reference (rsp_chan.noise_reference),
   .rsp_reference_valid (rsp_chan.reference_valid),
   .rsp_warming_up      (rsp_chan.warming_up)
);

/* dv/scac_checker.sv */
// Watches the request and response channels, predicts each classification and compares.
module scac_checker (
   input  logic                             clock,
   input  logic                             reset,
   scac_req_if                              req,
   scac_rsp_if                              rsp,
   input  logic                             csr_we,
   input  logic [scac_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [scac_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               failures,
   output int                               backlog
);
   timeunit 1ns;
   timeprecision 1ps;
   import scac_pkg::*;

   localparam int RISE_STEPS = 8;
   localparam int FALL_STEPS = 16;

   typedef struct packed {
      logic               full_tune;
      logic [NOISE_W-1:0] noise_reference;
      logic               reference_valid;
      logic               warming_up;
   } verdict_type;

   logic [BASE_W-1:0]  baseline [CHANNELS_DEFAULT];
   logic [NOISE_W-1:0] top_noise [TOP_DEPTH_DEFAULT];
   logic [NOISE_W-1:0] ref_level;
   logic               ref_valid;
   int                 score;
   int                 warm_count;
   logic               warm_on;
   logic               pend_flag;
   logic [CHAN_W-1:0]  pend_chan;
   logic [RSSI_W-1:0]  pend_rssi;
   logic [NOISE_W-1:0] pend_noise;
   cfg_type            cfg;
   verdict_type        verdicts [$];
   int                 mismatches = 0;

   function automatic void clear_classifier();
      foreach (baseline[i]) baseline[i] = UNKNOWN_BASELINE;
      foreach (top_noise[i]) top_noise[i] = '0;
      ref_level  = '0;
      ref_valid  = 1'b0;
      score      = 0;
      warm_count = 0;
      warm_on    = cfg.warmup_allowed;
      pend_flag  = 1'b0;
      pend_chan  = '0;
      pend_rssi  = '0;
      pend_noise = '0;
   endfunction

   function automatic void fold_baseline(logic [CHAN_W-1:0] ch, logic [RSSI_W-1:0] rssi);
      int unsigned b;
      b = baseline[ch];
      if (b == UNKNOWN_BASELINE) begin
         baseline[ch] = BASE_W'(rssi);
      end else begin
         baseline[ch] = BASE_W'((7 * b + rssi + 4) >> 3);
      end
   endfunction

   function automatic void track_noise(logic [NOISE_W-1:0] n);
      if (!ref_valid) begin
         ref_level = n;
         ref_valid = 1'b1;
         score     = 0;
      end else if (n > ref_level) begin
         if (score < RISE_STEPS) score++;
         if (score >= RISE_STEPS) begin
            ref_level++;
            score = 0;
         end
      end else if (n < ref_level) begin
         if (score > -FALL_STEPS) score--;
         if (score <= -FALL_STEPS) begin
            ref_level--;
            score = 0;
         end
      end
   endfunction

   function automatic verdict_type classify_request(item_type it);
      verdict_type       v;
      logic [BASE_W-1:0] base;
      int unsigned       trig;
      int unsigned       sq;
      int unsigned       lift;
      int unsigned       gate;
      logic              rssi_hit;
      logic              noise_hit;
      logic              tune;
      logic              placed;
      int                i;
      int                j;
      v.full_tune = 1'b0;
      case (it.mode)
         MODE_MEASURE: begin
            base = baseline[it.channel];
            trig = base + RSSI_MARGIN;
            if (trig > UNKNOWN_BASELINE) trig = UNKNOWN_BASELINE;
            sq = it.low_band ? cfg.sq_low : cfg.sq_high;
            sq = (sq > SQUELCH_MARGIN) ? sq - SQUELCH_MARGIN : 0;
            lift = it.rssi + WEAK_MARGIN;
            rssi_hit = (base == UNKNOWN_BASELINE) || (lift >= trig && lift >= sq);
            gate = (ref_level > NOISE_MARGIN) ? ref_level - NOISE_MARGIN : 0;
            noise_hit = ref_valid && (it.noise <= gate);
            if (warm_on) begin
               placed = 1'b0;
               for (i = 0; i < TOP_DEPTH_DEFAULT; i++) begin
                  if (!placed && it.noise > top_noise[i]) begin
                     for (j = TOP_DEPTH_DEFAULT - 1; j > i; j--) top_noise[j] = top_noise[j-1];
                     top_noise[i] = it.noise;
                     placed = 1'b1;
                  end
               end
               if (warm_count < WARMUP_COUNT_MAX) warm_count++;
               if (warm_count >= WARMUP_SAMPLES) begin
                  ref_level = top_noise[TOP_DEPTH_DEFAULT-1];
                  ref_valid = 1'b1;
                  warm_on   = 1'b0;
               end
               pend_flag = 1'b0;
            end else begin
               tune = (base == UNKNOWN_BASELINE && ref_valid) ? noise_hit
                                                              : (rssi_hit || noise_hit);
               if (tune) begin
                  pend_flag   = 1'b1;
                  pend_chan   = it.channel;
                  pend_rssi   = it.rssi;
                  pend_noise  = it.noise;
                  v.full_tune = 1'b1;
               end else begin
                  fold_baseline(it.channel, it.rssi);
                  track_noise(it.noise);
                  pend_flag = 1'b0;
               end
            end
         end
         MODE_COMMIT: begin
            if (pend_flag) begin
               fold_baseline(pend_chan, pend_rssi);
               track_noise(pend_noise);
               pend_flag  = 1'b0;
               pend_noise = '0;
               pend_rssi  = '0;
            end
         end
         MODE_DROP: begin
            pend_flag = 1'b0;
         end
         default: begin
            clear_classifier();
         end
      endcase
      v.noise_reference = ref_level;
      v.reference_valid = ref_valid;
      v.warming_up      = warm_on;
      return v;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      verdict_type want;
      if (reset) begin
         cfg.sq_low         = '0;
         cfg.sq_high        = '0;
         cfg.warmup_allowed = 1'b1;
         clear_classifier();
         verdicts.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SQUELCH_LOW:    cfg.sq_low = csr_wdata;
               CSR_SQUELCH_HIGH:   cfg.sq_high = csr_wdata;
               CSR_WARMUP_ALLOWED: cfg.warmup_allowed = csr_wdata[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            verdicts.push_back(classify_request(item_type'{mode: mode_type'(req.mode),
                                                           channel: req.channel_index,
                                                           rssi: req.rssi_level,
                                                           noise: req.noise_level,
                                                           low_band: req.low_band}));
         end
         if (rsp.valid && rsp.ready) begin
            if (verdicts.size() == 0) begin
               $error("response arrived with no request outstanding");
               mismatches++;
            end else begin
               want = verdicts.pop_front();
               check_field("full_tune", want.full_tune, rsp.full_tune);
               check_field("noise_reference", want.noise_reference, rsp.noise_reference);
               check_field("reference_valid", want.reference_valid, rsp.reference_valid);
               check_field("warming_up", want.warming_up, rsp.warming_up);
            end
         end
      end
      failures <= mismatches;
      backlog  <= verdicts.size();
   end

endmodule

/* dv/testbench.sv */
// Testbench top: clock, reset, request and threshold stimulus, response stalls and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import scac_pkg::*;

   localparam int                     CYCLE_LIMIT  = 400_000;
   localparam int                     HOLD_CYCLES  = 150;
   localparam int                     PHASES       = 6;
   localparam int                     PHASE_ITEMS  = 185;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE    = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     failures;
   int                     backlog;
   int                     cycles = 0;
   logic                   squeeze = 1'b0;
   int                     burst_left = 0;
   int                     steady_left = 0;
   int                     mode_tally [4] = '{0, 0, 0, 0};
   int                     chan_level [16];
   int                     noise_center;
   mode_type               last_mode = MODE_RESTART;

   scac_req_if req_chan ();
   scac_rsp_if rsp_chan ();

   scan_channel_activity_classifier DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   scac_checker activity_watch (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .backlog   (backlog)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int hold_left;
      int stretch_left;
      int ready_odds;
      logic hold_done;
      rsp_chan.ready = 1'b0;
      hold_left    = 0;
      stretch_left = 0;
      ready_odds   = 100;
      hold_done    = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            if (stretch_left == 0) begin
               case ($urandom_range(0, 3))
                  0: ready_odds = 100;
                  1: ready_odds = 50;
                  2: ready_odds = 90;
                  default: ready_odds = 25;
               endcase
               stretch_left = $urandom_range(4, 40);
            end
            stretch_left--;
            rsp_chan.ready <= ($urandom_range(1, 100) <= ready_odds);
         end
      end
   end

   function automatic int clamp(int v, int hi);
      return (v < 0) ? 0 : ((v > hi) ? hi : v);
   endfunction

   function automatic item_type make_item(mode_type m, int ch, int rssi, int noise, bit lb);
      item_type it;
      it.mode     = m;
      it.channel  = CHAN_W'(ch);
      it.rssi     = RSSI_W'(rssi);
      it.noise    = NOISE_W'(noise);
      it.low_band = lb;
      return it;
   endfunction

   function automatic item_type random_request();
      mode_type m;
      int       ch;
      int       rssi;
      int       noise;
      int       offset;
      int       pick;
      if (last_mode == MODE_MEASURE && $urandom_range(0, 1)) begin
         m = $urandom_range(0, 1) ? MODE_COMMIT : MODE_DROP;
      end else begin
         pick = $urandom_range(0, 199);
         if (pick < 140) m = MODE_MEASURE;
         else if (pick < 165) m = MODE_COMMIT;
         else if (pick < 196) m = MODE_DROP;
         else m = MODE_RESTART;
      end
      last_mode = m;
      if (m != MODE_MEASURE) begin
         return make_item(m, $urandom_range(0, 255), $urandom_range(0, 511),
                          $urandom_range(0, 255), $urandom_range(0, 1));
      end
      if ($urandom_range(0, 49) == 0) noise_center = $urandom_range(10, 245);
      ch = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
      pick = $urandom_range(0, 19);
      offset = $urandom_range(0, 56);
      case (pick)
         0: rssi = 0;
         1: rssi = 511;
         2, 3: rssi = $urandom_range(0, 511);
         default: rssi = clamp(chan_level[ch % 16] + offset - 16, 511);
      endcase
      pick = $urandom_range(0, 19);
      offset = $urandom_range(0, 20);
      case (pick)
         0: noise = 0;
         1: noise = 255;
         2: noise = $urandom_range(0, 255);
         default: noise = clamp(noise_center + offset - 12, 255);
      endcase
      return make_item(m, ch, rssi, noise, $urandom_range(0, 1));
   endfunction

   task automatic send_request(input item_type it);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (steady_left == 0 && $urandom_range(0, 3) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      if (steady_left > 0) steady_left--;
      req_chan.valid         <= 1'b1;
      req_chan.mode          <= it.mode;
      req_chan.channel_index <= it.channel;
      req_chan.rssi_level    <= it.rssi;
      req_chan.noise_level   <= it.noise;
      req_chan.low_band      <= it.low_band;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      mode_tally[it.mode]++;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_thresholds(input logic [7:0] low, input logic [7:0] high, input bit warm);
      csr_we    <= 1'b1;
      csr_index <= CSR_SQUELCH_LOW;
      csr_wdata <= low;
      @(posedge clock);
      csr_index <= CSR_SQUELCH_HIGH;
      csr_wdata <= high;
      @(posedge clock);
      csr_index <= CSR_WARMUP_ALLOWED;
      csr_wdata <= {7'($urandom), warm};
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= 8'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int p;
      int n;
      req_chan.valid         = 1'b0;
      req_chan.mode          = MODE_MEASURE;
      req_chan.channel_index = '0;
      req_chan.rssi_level    = '0;
      req_chan.noise_level   = '0;
      req_chan.low_band      = 1'b0;
      csr_we                 = 1'b0;
      csr_index              = CSR_SQUELCH_LOW;
      csr_wdata              = '0;
      reset                  = 1'b1;
      foreach (chan_level[i]) chan_level[i] = $urandom_range(0, 480);
      noise_center = $urandom_range(20, 235);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      load_thresholds(8'hFF, 8'h00, 1'b0);
      send_request(make_item(MODE_MEASURE, 17, 100, 40, 0));
      send_request(make_item(MODE_RESTART, 0, 0, 0, 0));
      send_request(make_item(MODE_COMMIT, 255, 511, 255, 1));
      send_request(make_item(MODE_MEASURE, 0, 511, 255, 1));
      send_request(make_item(MODE_COMMIT, 0, 0, 0, 0));
      send_request(make_item(MODE_MEASURE, 0, 511, 255, 1));
      send_request(make_item(MODE_MEASURE, 255, 0, 0, 0));
      send_request(make_item(MODE_DROP, 0, 0, 0, 0));
      send_request(make_item(MODE_COMMIT, 0, 0, 0, 0));
      send_request(make_item(MODE_MEASURE, 255, 0, 250, 0));
      send_request(make_item(MODE_DROP, 255, 511, 255, 1));
      send_request(make_item(MODE_MEASURE, 255, 0, 251, 0));
      send_request(make_item(MODE_MEASURE, 255, 8, 251, 1));
      send_request(make_item(MODE_COMMIT, 0, 0, 0, 0));
      send_request(make_item(MODE_MEASURE, 255, 7, 251, 0));
      send_request(make_item(MODE_MEASURE, 0, 300, 255, 0));
      send_request(make_item(MODE_RESTART, 255, 511, 255, 1));

      for (p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: load_thresholds(8'h00, 8'hFF, 1'b1);
            1: load_thresholds(8'hFF, 8'h00, 1'b0);
            2: load_thresholds(8'($urandom), 8'($urandom), 1'b1);
            3: load_thresholds(8'd8, 8'd9, 1'b0);
            4: load_thresholds(8'($urandom), 8'($urandom), 1'($urandom));
            default: load_thresholds(8'hFF, 8'hFF, 1'b1);
         endcase
         if (p != 3) send_request(make_item(MODE_RESTART, $urandom_range(0, 255),
                                            $urandom_range(0, 511), $urandom_range(0, 255),
                                            $urandom_range(0, 1)));
         if (p == 1) begin
            squeeze <= 1'b1;
            steady_left = 40;
         end
         for (n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
      end

      settle();
      repeat (8) @(posedge clock);
      $display("covered %0d requests: %0d measure, %0d commit, %0d drop, %0d restart",
               mode_tally[0] + mode_tally[1] + mode_tally[2] + mode_tally[3],
               mode_tally[MODE_MEASURE], mode_tally[MODE_COMMIT], mode_tally[MODE_DROP],
               mode_tally[MODE_RESTART]);
      $display("across %0d threshold settings, with bursty requests and one long response stall",
               PHASES + 1);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
